// ===== hdl/rmq_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion unit
package rmq_pkg;

  localparam int unsigned DataW = 16;

  typedef struct packed {
    logic signed [DataW-1:0] m00;
    logic signed [DataW-1:0] m01;
    logic signed [DataW-1:0] m02;
    logic signed [DataW-1:0] m10;
    logic signed [DataW-1:0] m11;
    logic signed [DataW-1:0] m12;
    logic signed [DataW-1:0] m20;
    logic signed [DataW-1:0] m21;
    logic signed [DataW-1:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [DataW-1:0] qw;
    logic signed [DataW-1:0] qx;
    logic signed [DataW-1:0] qy;
    logic signed [DataW-1:0] qz;
    logic                    degenerate;
  } quat_t;

  // which quaternion component gets the square-root half part
  typedef enum logic [1:0] {
    PickW = 2'd0,
    PickX = 2'd1,
    PickY = 2'd2,
    PickZ = 2'd3
  } pick_e;

endpackage

// ===== hdl/rmq_if.sv =====
// valid/ready channel interfaces for matrix and quaternion beats
interface rmq_mat_if;
  logic          valid;
  logic          ready;
  rmq_pkg::mat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rmq_quat_if;
  logic           valid;
  logic           ready;
  rmq_pkg::quat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/rmq_sqrt_stage.sv =====
// one registered step of a restoring integer square root
module rmq_sqrt_stage #(
  parameter int unsigned RadW = 36,
  parameter int unsigned ResW = 18,
  parameter int unsigned Step = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [RadW-1:0] rem_i,
  input  logic [ResW-1:0] root_i,
  output logic [RadW-1:0] rem_o,
  output logic [ResW-1:0] root_o
);

  localparam int unsigned Shift = 2 * (ResW - 1 - Step);

  logic [RadW+1:0] trial;
  logic [RadW+1:0] rem_w;
  logic [RadW-1:0] rem_d;
  logic [ResW-1:0] root_d;
  logic [RadW-1:0] rem_q;
  logic [ResW-1:0] root_q;

  // trial subtract (4*root+1) << shift
  always_comb begin
    trial  = ({{(RadW + 2 - ResW){1'b0}}, root_i} << (Shift + 2))
           | ((RadW + 2)'(1) << Shift);
    rem_w  = {2'b00, rem_i};
    rem_d  = rem_i;
    root_d = root_i << 1;
    if (rem_w >= trial) begin
      rem_d  = RadW'(rem_w - trial);
      root_d = (root_i << 1) | ResW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// ===== hdl/rmq_div_stage.sv =====
// one registered step of a restoring unsigned divider
module rmq_div_stage #(
  parameter int unsigned NumW = 34,
  parameter int unsigned DenW = 19,
  parameter int unsigned Step = 0
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  input  logic [NumW-1:0] quo_i,
  output logic [NumW-1:0] quo_o,
  output logic [DenW:0]   rem_o,
  input  logic [DenW:0]   rem_i
);

  logic [DenW+1:0] part;
  logic [DenW:0]   rem_d;
  logic [NumW-1:0] quo_d;
  logic [DenW:0]   rem_q;
  logic [NumW-1:0] quo_q;

  // shift in one numerator bit, subtract when it fits
  always_comb begin
    part  = {rem_i, num_i[NumW-1-Step]};
    quo_d = quo_i;
    rem_d = part[DenW:0];
    if (part >= {1'b0, 1'b0, den_i}) begin
      rem_d = (DenW + 1)'(part - {2'b00, den_i});
      quo_d[NumW-1-Step] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// ===== hdl/rotation_matrix_to_quaternion_unit.sv =====
// Rotation matrix to quaternion (Shepperd) as a stall-able pipeline. One matrix beat
// is taken every cycle while the output is not stalled. Each result passes a front
// stage for the case select, the bit-serial square root (one stage per root bit,
// (RadBW+FRAC_BITS+2+1)/2 rounded down, 18 stages at FRAC_BITS = 14), the divider
// (one stage per numerator bit, FRAC_BITS+19 stages, 33 at FRAC_BITS = 14) and a
// final stage for rounding and saturation, 53 register stages at the default.
// All stages advance together; a stalled output holds the whole pipe, so nothing is
// lost or repeated. A zero or negative radicand gives a zero quaternion with
// degenerate set.
module rotation_matrix_to_quaternion_unit #(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rmq_mat_if.sink     in_i,
  rmq_quat_if.source  out_o
);

  localparam int unsigned DW    = rmq_pkg::DataW;
  // signed width for trace and radicand: three entries plus ONE
  localparam int unsigned AW    = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 2;
  // radicand is positive and below 2^(AW-1), X4 = rad << (FRAC_BITS+2)
  localparam int unsigned RadBW = AW;
  localparam int unsigned X4W   = RadBW + FRAC_BITS + 2 + ((RadBW + FRAC_BITS) % 2);
  localparam int unsigned RtW   = X4W / 2;
  // numerator magnitude: 18-bit diff times 2^(FRAC_BITS-1), doubled, plus den
  localparam int unsigned NumW  = 18 + FRAC_BITS + 1;
  localparam int unsigned DenW  = RtW + 1;
  localparam int unsigned SqN   = RtW;
  localparam int unsigned DvN   = NumW;
  localparam int unsigned Depth = 1 + SqN + DvN + 1;
  localparam int unsigned NOne  = 3;

  typedef struct packed {
    logic [RadBW-1:0]      rad;
    logic [2:0][17:0]      nmag;
    logic [2:0]            nneg;
    rmq_pkg::pick_e        pick;
    logic                  degen;
  } front_t;

  // pipeline control
  logic [Depth-1:0] vld_q;
  logic             adv;
  assign adv       = !vld_q[Depth-1] || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Depth-2:0], in_i.valid};
    end
  end

  // front: case select, radicand and the three numerators
  front_t f_d, f_q;
  always_comb begin
    logic signed [AW-1:0] d00, d11, d22, tr, rd, one;
    logic signed [17:0]   n0, n1, n2;
    logic [1:0]           ii;
    d00 = AW'(in_i.data.m00);
    d11 = AW'(in_i.data.m11);
    d22 = AW'(in_i.data.m22);
    one = AW'(1) <<< FRAC_BITS;
    tr  = d00 + d11 + d22;
    ii  = 2'd0;
    n0 = '0; n1 = '0; n2 = '0; rd = '0;
    f_d = '0;
    if (tr > 0) begin
      f_d.pick = rmq_pkg::PickW;
      rd = tr + one;
      n0 = 18'(in_i.data.m21) - 18'(in_i.data.m12);
      n1 = 18'(in_i.data.m02) - 18'(in_i.data.m20);
      n2 = 18'(in_i.data.m10) - 18'(in_i.data.m01);
    end else begin
      if (d11 > d00) ii = 2'd1;
      if (d22 > ((ii == 2'd1) ? d11 : d00)) ii = 2'd2;
      case (ii)
        2'd0: begin
          f_d.pick = rmq_pkg::PickX;
          rd = d00 - d11 - d22 + one;
          n0 = 18'(in_i.data.m21) - 18'(in_i.data.m12);
          n1 = 18'(in_i.data.m10) + 18'(in_i.data.m01);
          n2 = 18'(in_i.data.m20) + 18'(in_i.data.m02);
        end
        2'd1: begin
          f_d.pick = rmq_pkg::PickY;
          rd = d11 - d22 - d00 + one;
          n0 = 18'(in_i.data.m02) - 18'(in_i.data.m20);
          n1 = 18'(in_i.data.m21) + 18'(in_i.data.m12);
          n2 = 18'(in_i.data.m01) + 18'(in_i.data.m10);
        end
        default: begin
          f_d.pick = rmq_pkg::PickZ;
          rd = d22 - d00 - d11 + one;
          n0 = 18'(in_i.data.m10) - 18'(in_i.data.m01);
          n1 = 18'(in_i.data.m02) + 18'(in_i.data.m20);
          n2 = 18'(in_i.data.m12) + 18'(in_i.data.m21);
        end
      endcase
    end
    f_d.degen = (rd <= 0);
    f_d.rad   = f_d.degen ? RadBW'(1) : RadBW'(rd);
    f_d.nneg  = {n2[17], n1[17], n0[17]};
    f_d.nmag[0] = n0[17] ? 18'(-n0) : n0;
    f_d.nmag[1] = n1[17] ? 18'(-n1) : n1;
    f_d.nmag[2] = n2[17] ? 18'(-n2) : n2;
  end

  always_ff @(posedge clk_i) begin
    if (adv) f_q <= f_d;
  end

  // square root of 4X, one root bit per stage; side data rides along
  logic [X4W-1:0] sq_rem [SqN+1];
  logic [RtW-1:0] sq_rt  [SqN+1];
  front_t         sq_f   [SqN+1];
  assign sq_rem[0] = X4W'(f_q.rad) << (FRAC_BITS + 2);
  assign sq_rt[0]  = '0;
  assign sq_f[0]   = f_q;

  for (genvar g = 0; g < SqN; g++) begin : g_sqrt
    rmq_sqrt_stage #(.RadW(X4W), .ResW(RtW), .Step(g)) u_sq (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (sq_rem[g]),
      .root_i(sq_rt[g]),
      .rem_o (sq_rem[g+1]),
      .root_o(sq_rt[g+1])
    );
    always_ff @(posedge clk_i) begin
      if (adv) sq_f[g+1] <= sq_f[g];
    end
  end

  // rounded root S = (isqrt(4X)+1)>>1; half part (isqrt(X)+1)>>1
  logic [DenW-1:0] s_rnd;
  logic [DenW-1:0] half_w;
  assign s_rnd  = DenW'((DenW'(sq_rt[SqN]) + DenW'(1)) >> 1);
  assign half_w = ((DenW'(sq_rt[SqN]) >> 1) + DenW'(1)) >> 1;

  // divider lanes: (2*mag*2^(F-1) + S) / (2S)
  typedef struct packed {
    logic [DenW-1:0] den;
    logic [DenW-1:0] half;
    logic [2:0]      nneg;
    rmq_pkg::pick_e  pick;
    logic            degen;
  } side_t;

  side_t           dv_s [DvN+1];
  logic [NumW-1:0] dv_n [NOne][DvN+1];
  logic [NumW-1:0] dv_qu[NOne][DvN+1];
  logic [DenW+1:0] dv_r [NOne][DvN+1];

  assign dv_s[0].den   = s_rnd;
  assign dv_s[0].half  = half_w;
  assign dv_s[0].nneg  = sq_f[SqN].nneg;
  assign dv_s[0].pick  = sq_f[SqN].pick;
  assign dv_s[0].degen = sq_f[SqN].degen;

  for (genvar l = 0; l < NOne; l++) begin : g_lane
    assign dv_n[l][0]  = NumW'((NumW'(sq_f[SqN].nmag[l]) << FRAC_BITS) + NumW'(s_rnd));
    assign dv_qu[l][0] = '0;
    assign dv_r[l][0]  = '0;
    for (genvar g = 0; g < DvN; g++) begin : g_div
      rmq_div_stage #(.NumW(NumW), .DenW(DenW + 1), .Step(g)) u_dv (
        .clk_i(clk_i),
        .en_i (adv),
        .num_i(dv_n[l][g]),
        .den_i({dv_s[g].den, 1'b0}),
        .quo_i(dv_qu[l][g]),
        .quo_o(dv_qu[l][g+1]),
        .rem_o(dv_r[l][g+1]),
        .rem_i(dv_r[l][g])
      );
      always_ff @(posedge clk_i) begin
        if (adv) dv_n[l][g+1] <= dv_n[l][g];
      end
    end
  end

  for (genvar g = 0; g < DvN; g++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (adv) dv_s[g+1] <= dv_s[g];
    end
  end

  // saturate to +-ONE then to 16-bit range
  function automatic logic [DW-1:0] sat_part(input logic [NumW-1:0] mag, input logic neg);
    logic [NumW:0] one_w, lim;
    one_w = (NumW + 1)'(1) << FRAC_BITS;
    lim   = one_w;
    if (!neg && lim > (NumW + 1)'(32767)) lim = (NumW + 1)'(32767);
    if (neg && lim > (NumW + 1)'(32768)) lim = (NumW + 1)'(32768);
    if ({1'b0, mag} > lim) sat_part = neg ? DW'(-lim) : DW'(lim);
    else sat_part = neg ? DW'(-{1'b0, mag}) : DW'(mag);
  endfunction

  rmq_pkg::quat_t o_d, o_q;
  always_comb begin
    logic [DW-1:0] hp, a0, a1, a2;
    hp = sat_part(NumW'(dv_s[DvN].half), 1'b0);
    a0 = sat_part(dv_qu[0][DvN], dv_s[DvN].nneg[0]);
    a1 = sat_part(dv_qu[1][DvN], dv_s[DvN].nneg[1]);
    a2 = sat_part(dv_qu[2][DvN], dv_s[DvN].nneg[2]);
    o_d = '0;
    case (dv_s[DvN].pick)
      rmq_pkg::PickW: begin
        o_d.qw = hp; o_d.qx = a0; o_d.qy = a1; o_d.qz = a2;
      end
      rmq_pkg::PickX: begin
        o_d.qx = hp; o_d.qw = a0; o_d.qy = a1; o_d.qz = a2;
      end
      rmq_pkg::PickY: begin
        o_d.qy = hp; o_d.qw = a0; o_d.qz = a1; o_d.qx = a2;
      end
      default: begin
        o_d.qz = hp; o_d.qw = a0; o_d.qx = a1; o_d.qy = a2;
      end
    endcase
    if (dv_s[DvN].degen) begin
      o_d = '0;
      o_d.degenerate = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) o_q <= o_d;
  end

  assign out_o.valid = vld_q[Depth-1];
  assign out_o.data  = o_q;

endmodule

// ===== sim/rotation_matrix_to_quaternion_unit_test.sv =====
// testbench for the rotation matrix to quaternion unit: directed table then random beats
module rotation_matrix_to_quaternion_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FracBits = 14;
  localparam int Latency = 80;
  localparam int RandItems = 1850;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #5 clk_i = ~clk_i;

  rmq_mat_if  mat_ch ();
  rmq_quat_if quat_ch ();

  rotation_matrix_to_quaternion_unit #(.FRAC_BITS(FracBits)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (mat_ch.sink),
    .out_o (quat_ch.source)
  );

  rmq_pkg::quat_t pending_quats[$];
  int err_cnt = 0;
  bit no_idle = 1'b0;
  bit drain_done = 1'b0;

  // integer square root, floor
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // divide, rounding to nearest with ties away from zero
  function automatic longint round_div(longint n, longint unsigned d);
    longint unsigned mag, q;
    mag = (n < 0) ? longint'(-n) : n;
    q = (2 * mag + d) / (2 * d);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic [15:0] sat_part(longint v);
    longint one;
    one = longint'(1) << FracBits;
    if (v > one) v = one;
    if (v < -one) v = -one;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // shepperd conversion at the block's precision
  function automatic rmq_pkg::quat_t shepperd_quat(rmq_pkg::mat_t mt);
    longint m[3][3];
    longint q[4];
    longint one, scale, tr, rad;
    longint unsigned xs, sr;
    int i, j, k;
    rmq_pkg::quat_t r;
    m[0][0] = mt.m00; m[0][1] = mt.m01; m[0][2] = mt.m02;
    m[1][0] = mt.m10; m[1][1] = mt.m11; m[1][2] = mt.m12;
    m[2][0] = mt.m20; m[2][1] = mt.m21; m[2][2] = mt.m22;
    one = longint'(1) << FracBits;
    scale = longint'(1) << (FracBits - 1);
    q = '{0, 0, 0, 0};
    r.degenerate = 1'b0;
    tr = m[0][0] + m[1][1] + m[2][2];
    if (tr > 0) begin
      xs = longint'(tr + one) << FracBits;
      sr = (int_sqrt(4 * xs) + 1) >> 1;
      q[0] = (int_sqrt(xs) + 1) >> 1;
      q[1] = round_div((m[2][1] - m[1][2]) * scale, sr);
      q[2] = round_div((m[0][2] - m[2][0]) * scale, sr);
      q[3] = round_div((m[1][0] - m[0][1]) * scale, sr);
    end else begin
      i = 0;
      if (m[1][1] > m[0][0]) i = 1;
      if (m[2][2] > m[i][i]) i = 2;
      j = (i + 1) % 3;
      k = (j + 1) % 3;
      rad = m[i][i] - m[j][j] - m[k][k] + one;
      if (rad <= 0) begin
        r.degenerate = 1'b1;
      end else begin
        xs = longint'(rad) << FracBits;
        sr = (int_sqrt(4 * xs) + 1) >> 1;
        q[1 + i] = (int_sqrt(xs) + 1) >> 1;
        q[0] = round_div((m[k][j] - m[j][k]) * scale, sr);
        q[1 + j] = round_div((m[j][i] + m[i][j]) * scale, sr);
        q[1 + k] = round_div((m[k][i] + m[i][k]) * scale, sr);
      end
    end
    r.qw = sat_part(q[0]);
    r.qx = sat_part(q[1]);
    r.qy = sat_part(q[2]);
    r.qz = sat_part(q[3]);
    return r;
  endfunction

  // one beat through the input channel, with optional idle burst first
  task automatic send_mat(rmq_pkg::mat_t mt, bit use_typed, rmq_pkg::quat_t typed);
    int gap;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      mat_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    mat_ch.valid <= 1'b1;
    mat_ch.data <= mt;
    pending_quats.push_back(use_typed ? typed : shepperd_quat(mt));
    @(posedge clk_i);
    while (!mat_ch.ready) @(posedge clk_i);
  endtask

  function automatic rmq_pkg::mat_t rand_mat();
    logic [159:0] raw;
    rmq_pkg::mat_t mt;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    mt = raw[143:0];
    return mt;
  endfunction

  // a near-rotation: signed permutation with small noise, hits every branch
  function automatic rmq_pkg::mat_t rand_rot();
    logic signed [15:0] e[9];
    int p, n;
    int perms[6][3] = '{'{0,1,2}, '{1,2,0}, '{2,0,1}, '{0,2,1}, '{2,1,0}, '{1,0,2}};
    p = $urandom_range(0, 5);
    n = $urandom_range(0, 4000);
    for (int a = 0; a < 9; a++) e[a] = 16'($urandom_range(0, 2 * n) - n);
    for (int a = 0; a < 3; a++)
      e[a * 3 + perms[p][a]] = 16'(($urandom_range(0, 1) ? 16384 : -16384)
                                   + ($urandom_range(0, 2 * n) - n));
    return {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
  endfunction

  // receiver with random stall bursts
  initial begin
    int st;
    quat_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!no_idle && $urandom_range(0, 3) == 0) begin
        st = $urandom_range(1, 17);
        quat_ch.ready <= 1'b0;
        repeat (st) @(posedge clk_i);
      end
      quat_ch.ready <= 1'b1;
      @(posedge clk_i);
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk_i) begin
    rmq_pkg::quat_t got, want;
    if (rst_ni && quat_ch.valid && quat_ch.ready) begin
      got = quat_ch.data;
      if (pending_quats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, got);
        err_cnt++;
      end else begin
        want = pending_quats.pop_front();
        if (got.qw !== want.qw) begin
          $display("%0t: qw expected %h actual %h", $time, want.qw, got.qw); err_cnt++;
        end
        if (got.qx !== want.qx) begin
          $display("%0t: qx expected %h actual %h", $time, want.qx, got.qx); err_cnt++;
        end
        if (got.qy !== want.qy) begin
          $display("%0t: qy expected %h actual %h", $time, want.qy, got.qy); err_cnt++;
        end
        if (got.qz !== want.qz) begin
          $display("%0t: qz expected %h actual %h", $time, want.qz, got.qz); err_cnt++;
        end
        if (got.degenerate !== want.degenerate) begin
          $display("%0t: degenerate expected %b actual %b", $time, want.degenerate,
                   got.degenerate);
          err_cnt++;
        end
      end
    end
  end

  typedef struct {
    rmq_pkg::mat_t  mt;
    bit             typed;
    rmq_pkg::quat_t q;
  } dir_row_t;

  localparam logic signed [15:0] One = 16'sd16384;

  initial begin
    dir_row_t rows[$];
    int wait_cnt;
    mat_ch.valid = 1'b0;
    mat_ch.data = '0;
    // identity, w = 1
    rows.push_back('{{One, 16'sd0, 16'sd0, 16'sd0, One, 16'sd0, 16'sd0, 16'sd0, One},
                    1, '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 1'b0}});
    // half turns about x, y, z
    rows.push_back('{{One, 16'sd0, 16'sd0, 16'sd0, -One, 16'sd0, 16'sd0, 16'sd0, -One},
                    1, '{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 1'b0}});
    rows.push_back('{{-One, 16'sd0, 16'sd0, 16'sd0, One, 16'sd0, 16'sd0, 16'sd0, -One},
                    1, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 1'b0}});
    rows.push_back('{{-One, 16'sd0, 16'sd0, 16'sd0, -One, 16'sd0, 16'sd0, 16'sd0, One},
                    1, '{16'sd0, 16'sd0, 16'sd0, 16'sd16384, 1'b0}});
    // all zero: trace 0, radicand one
    rows.push_back('{'0, 0, '0});
    // most negative diagonal, radicand still positive
    rows.push_back('{{-16'sd32768, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 16'sd0, 16'sd0,
                      16'sd0, -16'sd32768}, 0, '0});
    rows.push_back('{{-One, 16'sd5, 16'sd0, 16'sd0, -One, 16'sd0, 16'sd0, 16'sd0, -One},
                    0, '0});
    // field extremes, saturating parts
    rows.push_back('{{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767,
                      16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767}, 0, '0});
    rows.push_back('{{16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, 16'sd32767,
                      -16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767}, 0, '0});
    rows.push_back('{{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                      16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767}, 0, '0});
    // diagonal ties go to the lower index
    rows.push_back('{{-16'sd100, 16'sd7, 16'sd9, 16'sd3, -16'sd100, 16'sd2, 16'sd1, 16'sd4,
                      -16'sd100}, 0, '0});
    rows.push_back('{{-16'sd9000, 16'sd7, 16'sd9, 16'sd3, -16'sd100, 16'sd2, 16'sd1, 16'sd4,
                      -16'sd100}, 0, '0});
    rows.push_back('{{16'sd1, -16'sd1, 16'sd1, -16'sd1, 16'sd0, 16'sd1, -16'sd1, 16'sd1,
                      -16'sd1}, 0, '0});
    rows.push_back('{'1, 0, '0});
    rows.push_back('{'0, 0, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[r]) send_mat(rows[r].mt, rows[r].typed, rows[r].q);

    // hold off until the pipe has drained
    mat_ch.valid <= 1'b0;
    while (pending_quats.size() != 0) @(posedge clk_i);

    for (int n = 0; n < RandItems; n++) begin
      if (n == RandItems - 200) no_idle = 1'b1;
      send_mat($urandom_range(0, 3) == 0 ? rand_mat() : rand_rot(), 0, '0);
    end
    mat_ch.valid <= 1'b0;

    wait_cnt = 0;
    while (pending_quats.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (Latency) @(posedge clk_i);
    drain_done = 1'b1;
    if (err_cnt == 0 && pending_quats.size() == 0) begin
      $display("rotation_matrix_to_quaternion_unit_test: done, clean");
    end else begin
      $display("rotation_matrix_to_quaternion_unit_test: done, errors");
    end
    $finish;
  end

  // overall watchdog
  initial begin
    #5ms;
    if (!drain_done) $display("rotation_matrix_to_quaternion_unit_test: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rmq_pkg.sv
hdl/rmq_if.sv
hdl/rmq_sqrt_stage.sv
hdl/rmq_div_stage.sv
hdl/rotation_matrix_to_quaternion_unit.sv
sim/rotation_matrix_to_quaternion_unit_test.sv
